// ----- rtl/wlh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wlh_pkg
// Shared types and constants for the wait latency log2 histogram block.
// ----------------------------------------------------------------------------
package wlh_pkg;

   localparam int HIST_BUCKETS_DEF = 27;
   localparam int ID_SPACE_DEF     = 16384;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 14;
   localparam int TIME_W   = 64;
   localparam int BUCKET_W = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 64;

   typedef enum logic [KIND_W-1:0] {
      KIND_WAKE   = 2'd0,
      KIND_SWITCH = 2'd1,
      KIND_READ   = 2'd2,
      KIND_NONE   = 2'd3
   } wlh_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_WAKE    = 2'd0,
      STAT_COUNTED = 2'd1,
      STAT_SKIPPED = 2'd2,
      STAT_READ    = 2'd3
   } wlh_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_BIN,
      S_COUNT,
      S_HREAD,
      S_EMIT
   } wlh_state_type;

endpackage
`default_nettype wire

// ----- rtl/wlh_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wlh_req_if / wlh_rsp_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface wlh_req_if
   import wlh_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     task_id;
   logic [TIME_W-1:0]   now_ns;
   logic [BUCKET_W-1:0] read_bucket;

   modport source (output valid, kind, task_id, now_ns, read_bucket, input ready);
   modport sink   (input valid, kind, task_id, now_ns, read_bucket, output ready);
endinterface

interface wlh_rsp_if
   import wlh_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BUCKET_W-1:0] bucket;
   logic [COUNT_W-1:0]  count;
   logic [TIME_W-1:0]   wait_ns;

   modport source (output valid, status, bucket, count, wait_ns, input ready);
   modport sink   (input valid, status, bucket, count, wait_ns, output ready);
endinterface
`default_nettype wire

// ----- rtl/wait_latency_log2_histogram_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wait_latency_log2_histogram_top
// Wakeup-to-switch wait measurement with a log2 histogram of the waits.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A counted switch goes through the wake
// table read, the subtract, the bucket search and histogram read, the counter
// increment and write back, and the load of the output register, in that
// order; a full output register holds the result back until it is free.
// After reset the wake table is swept to clear its valid flags, during which
// no item is accepted. Histogram counters clear at once through per-bucket
// valid flags.
// ----------------------------------------------------------------------------
module wait_latency_log2_histogram_top
   import wlh_pkg::*;
#(
   parameter int HIST_BUCKETS = HIST_BUCKETS_DEF,
   parameter int ID_SPACE     = ID_SPACE_DEF
) (
   input  wire        clock,
   input  wire        reset,
   wlh_req_if.sink    req_if,
   wlh_rsp_if.source  rsp_if
);

   localparam int IdW  = $clog2(ID_SPACE);
   localparam int BktW = $clog2(HIST_BUCKETS);
   localparam logic [IdW+ID_W-1:0]     IdLimit  = (IdW+ID_W)'(ID_SPACE);
   localparam logic [IdW-1:0]          IdLast   = IdW'(ID_SPACE - 1);
   localparam logic [BktW+BUCKET_W-1:0] BktLimit = (BktW+BUCKET_W)'(HIST_BUCKETS);
   localparam logic [5:0]              BktTop   = 6'(HIST_BUCKETS - 1);

   wlh_state_type state_ff, state_in;

   logic [IdW-1:0]      clr_ff, clr_in;
   logic [IdW-1:0]      idx_ff, idx_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [BUCKET_W-1:0] rb_ff, rb_in;
   logic                rb_ok_ff, rb_ok_in;
   logic [TIME_W-1:0]   wait_ff, wait_in;
   logic [5:0]          bkt_ff, bkt_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [BUCKET_W-1:0] res_bucket_ff, res_bucket_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;
   logic [TIME_W-1:0]   res_lat_ff, res_lat_in;

   logic                rsp_vld_ff, rsp_vld_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [TIME_W-1:0]   rsp_lat_ff, rsp_lat_in;

   logic [HIST_BUCKETS-1:0] hvld_ff, hvld_in;

   // wake table: valid flag over timestamp
   logic [TIME_W:0] wake_mem [ID_SPACE];
   logic [TIME_W:0] wrd_ff;
   logic            wwe, wre;
   logic [IdW-1:0]  waddr, raddr;
   logic [TIME_W:0] wdata;

   logic [COUNT_W-1:0] hist_mem [HIST_BUCKETS];
   logic [COUNT_W-1:0] hrd_ff;
   logic               hwe, hre;
   logic [BktW-1:0]    hwaddr, hraddr;
   logic [COUNT_W-1:0] hwdata;

   logic                   accept;
   logic                   out_free;
   logic [IdW+ID_W-1:0]    id_ext;
   logic [IdW-1:0]         id_idx;
   logic                   id_ok;
   logic [BktW+BUCKET_W-1:0] rb_ext;
   logic                   rb_ok;
   logic [BktW-1:0]        bkt_idx;
   logic [BktW-1:0]        rb_idx;
   logic [5:0]             msb;
   logic [5:0]             bkt_calc;
   logic [COUNT_W-1:0]     cnt_cur;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_vld_ff || rsp_if.ready;
   assign id_ext   = {{IdW{1'b0}}, req_if.task_id};
   assign id_idx   = id_ext[IdW-1:0];
   assign id_ok    = id_ext < IdLimit;
   assign rb_ext   = {{BktW{1'b0}}, req_if.read_bucket};
   assign rb_ok    = rb_ext < BktLimit;
   assign bkt_idx  = bkt_ff[BktW-1:0];
   assign rb_idx   = BktW'(rb_ff);

   always_comb begin
      msb = 6'd0;
      for (int i = 1; i < TIME_W; i++) begin
         if (wait_ff[i]) begin
            msb = 6'(i);
         end
      end
      bkt_calc = (msb >= BktTop) ? BktTop : msb;
   end

   assign cnt_cur = hvld_ff[bkt_idx] ? hrd_ff : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == IdLast) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (wlh_kind_type'(req_if.kind))
                  KIND_WAKE:   state_in = S_EMIT;
                  KIND_SWITCH: state_in = id_ok ? S_LOOKUP : S_EMIT;
                  KIND_READ:   state_in = S_HREAD;
                  KIND_NONE:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOOKUP: state_in = wrd_ff[TIME_W] ? S_BIN : S_EMIT;
         S_BIN:    state_in = S_COUNT;
         S_COUNT:  state_in = S_EMIT;
         S_HREAD:  state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default:  state_in = S_CLEAR;
      endcase
   end

   // controls
   always_comb begin
      req_if.ready = 1'b0;
      wwe    = 1'b0;
      waddr  = idx_ff;
      wdata  = '0;
      wre    = 1'b0;
      raddr  = id_idx;
      hwe    = 1'b0;
      hwaddr = bkt_idx;
      hwdata = cnt_cur + COUNT_W'(1);
      hre    = 1'b0;
      hraddr = bkt_calc[BktW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            wwe   = 1'b1;
            waddr = clr_ff;
         end
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (accept && id_ok && req_if.kind == KIND_WAKE) begin
               wwe   = 1'b1;
               waddr = id_idx;
               wdata = {1'b1, req_if.now_ns};
            end
            if (accept && id_ok && req_if.kind == KIND_SWITCH) begin
               wre = 1'b1;
            end
            if (accept && rb_ok && req_if.kind == KIND_READ) begin
               hre    = 1'b1;
               hraddr = rb_ext[BktW-1:0];
            end
         end
         S_LOOKUP: begin
            wwe = wrd_ff[TIME_W];
         end
         S_BIN:   hre = 1'b1;
         S_COUNT: hwe = 1'b1;
         S_HREAD, S_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      rb_in         = rb_ff;
      rb_ok_in      = rb_ok_ff;
      wait_in       = wait_ff;
      bkt_in        = bkt_ff;
      res_status_in = res_status_ff;
      res_bucket_in = res_bucket_ff;
      res_count_in  = res_count_ff;
      res_lat_in    = res_lat_ff;
      hvld_in       = hvld_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_lat_in    = rsp_lat_ff;
      unique case (state_ff)
         S_CLEAR: clr_in = clr_ff + IdW'(1);
         S_IDLE: begin
            if (accept) begin
               idx_in        = id_idx;
               now_in        = req_if.now_ns;
               rb_in         = req_if.read_bucket;
               rb_ok_in      = rb_ok;
               res_status_in = (req_if.kind == KIND_WAKE) ? STAT_WAKE : STAT_SKIPPED;
               res_bucket_in = '0;
               res_count_in  = '0;
               res_lat_in    = '0;
            end
         end
         S_LOOKUP: wait_in = now_ff - wrd_ff[TIME_W-1:0];
         S_BIN:    bkt_in  = bkt_calc;
         S_COUNT: begin
            hvld_in[bkt_idx] = 1'b1;
            res_status_in    = STAT_COUNTED;
            res_bucket_in    = bkt_ff[BUCKET_W-1:0];
            res_count_in     = hwdata;
            res_lat_in       = wait_ff;
         end
         S_HREAD: begin
            res_status_in = STAT_READ;
            res_bucket_in = rb_ff;
            res_count_in  = (rb_ok_ff && hvld_ff[rb_idx]) ? hrd_ff : '0;
            res_lat_in    = '0;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bucket_in = res_bucket_ff;
               rsp_count_in  = res_count_ff;
               rsp_lat_in    = res_lat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         hvld_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         hvld_ff    <= hvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      rb_ff         <= rb_in;
      rb_ok_ff      <= rb_ok_in;
      wait_ff       <= wait_in;
      bkt_ff        <= bkt_in;
      res_status_ff <= res_status_in;
      res_bucket_ff <= res_bucket_in;
      res_count_ff  <= res_count_in;
      res_lat_ff    <= res_lat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_lat_ff    <= rsp_lat_in;
   end

   always_ff @(posedge clock) begin
      if (wwe) wake_mem[waddr] <= wdata;
      if (wre) wrd_ff <= wake_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (hwe) hist_mem[hwaddr] <= hwdata;
      if (hre) hrd_ff <= hist_mem[hraddr];
   end

   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.status  = rsp_status_ff;
   assign rsp_if.bucket  = rsp_bucket_ff;
   assign rsp_if.count   = rsp_count_ff;
   assign rsp_if.wait_ns = rsp_lat_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> state_ff == S_IDLE)
      else $error("item accepted outside idle");

   a_count_marks_bucket: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COUNT |=> hvld_ff[bkt_idx])
      else $error("counted bucket not marked valid");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_vld_ff && !rsp_if.ready) |=> state_ff == S_EMIT)
      else $error("result dropped while output stalled");

endmodule
`default_nettype wire

// ----- dv/tb_wait_latency_log2_histogram_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_wait_latency_log2_histogram_top
// Drives wakeup, switch-in, bucket-read and ignored items into the histogram
// block and checks every reply against a local scoreboard. The scoreboard
// keeps its own wake table and log2 histogram. Directed cases come first:
// exact small waits, switches with no record, re-wakes, time wraparound, the
// top bucket and reads past the last bucket. Random traffic over a small pool
// of task ids follows, under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_wait_latency_log2_histogram_top
   import wlh_pkg::*;
   ();

   localparam int NBUCKETS    = HIST_BUCKETS_DEF;
   localparam int NIDS        = ID_SPACE_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      wlh_status_type      status;
      logic [BUCKET_W-1:0] bucket;
      logic [COUNT_W-1:0]  count;
      logic [TIME_W-1:0]   wait_ns;
   } wlh_reply_type;

   logic clock;
   logic reset;

   wlh_req_if req_ch ();
   wlh_rsp_if rsp_ch ();

   wait_latency_log2_histogram_top #(
      .HIST_BUCKETS(NBUCKETS),
      .ID_SPACE    (NIDS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // scoreboard state
   bit                 woken    [NIDS];
   logic [TIME_W-1:0]  woken_at [NIDS];
   logic [COUNT_W-1:0] wait_hist[NBUCKETS];
   wlh_reply_type      replies_due[$];

   int          fails = 0;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [BUCKET_W-1:0] wait_to_bucket(input logic [TIME_W-1:0] w);
      int msb;
      msb = 0;
      for (int i = 0; i < TIME_W; i++) begin
         if (w[i]) msb = i;
      end
      if (msb > NBUCKETS - 1) msb = NBUCKETS - 1;
      return BUCKET_W'(msb);
   endfunction

   // update the scoreboard with one accepted item and queue its reply
   task automatic tally_event(input wlh_kind_type k, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] t, input logic [BUCKET_W-1:0] rb);
      wlh_reply_type r;
      logic [TIME_W-1:0] w;
      logic [BUCKET_W-1:0] b;
      r = '0;
      case (k)
         KIND_WAKE: begin
            if (int'(id) < NIDS) begin
               woken[id]    = 1'b1;
               woken_at[id] = t;
            end
            r.status = STAT_WAKE;
            replies_due.push_back(r);
         end
         KIND_SWITCH: begin
            if (int'(id) >= NIDS || !woken[id]) begin
               r.status = STAT_SKIPPED;
            end else begin
               w         = t - woken_at[id];
               woken[id] = 1'b0;
               b         = wait_to_bucket(w);
               wait_hist[b] = wait_hist[b] + 1;
               r.status     = STAT_COUNTED;
               r.bucket     = b;
               r.count      = wait_hist[b];
               r.wait_ns    = w;
            end
            replies_due.push_back(r);
         end
         KIND_READ: begin
            r.status = STAT_READ;
            r.bucket = rb;
            r.count  = (int'(rb) < NBUCKETS) ? wait_hist[rb] : '0;
            replies_due.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   // entered and left at a falling edge
   task automatic send_event(input wlh_kind_type k, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] t, input logic [BUCKET_W-1:0] rb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= k;
      req_ch.task_id     <= id;
      req_ch.now_ns      <= t;
      req_ch.read_bucket <= rb;
      do @(posedge clock); while (!req_ch.ready);
      tally_event(k, id, t, rb);
      @(negedge clock);
   endtask

   task automatic wait_all_replies();
      req_ch.valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      wlh_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            $error("reply with none due: status %0d bucket %0d", rsp_ch.status, rsp_ch.bucket);
            fails++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               fails++;
            end
            if (rsp_ch.bucket !== want.bucket) begin
               $error("bucket: expected %0d, got %0d", want.bucket, rsp_ch.bucket);
               fails++;
            end
            if (rsp_ch.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
               fails++;
            end
            if (rsp_ch.wait_ns !== want.wait_ns) begin
               $error("wait_ns: expected %0d, got %0d", want.wait_ns, rsp_ch.wait_ns);
               fails++;
            end
         end
      end
   end

   // waits of 0, 1 and 3 land in buckets 0, 0 and 1
   task automatic test_exact_waits();
      send_event(KIND_WAKE,   14'd0,     64'd100,  5'd0);
      send_event(KIND_SWITCH, 14'd0,     64'd100,  5'd0);
      send_event(KIND_WAKE,   14'd0,     64'd5,    5'd0);
      send_event(KIND_SWITCH, 14'd0,     64'd6,    5'd0);
      send_event(KIND_WAKE,   14'h3FFF,  64'd1000, 5'd31);
      send_event(KIND_SWITCH, 14'h3FFF,  64'd1003, 5'd31);
   endtask

   task automatic test_missing_wakeup();
      send_event(KIND_SWITCH, 14'd12345, 64'd40, 5'd0);
      send_event(KIND_WAKE,   14'd77,    64'd50, 5'd0);
      send_event(KIND_SWITCH, 14'd77,    64'd60, 5'd0);
      send_event(KIND_SWITCH, 14'd77,    64'd70, 5'd0);
   endtask

   // a second wakeup replaces the stored time
   task automatic test_rewake();
      send_event(KIND_WAKE,   14'd9, 64'd10,   5'd0);
      send_event(KIND_WAKE,   14'd9, 64'd1000, 5'd0);
      send_event(KIND_SWITCH, 14'd9, 64'd1010, 5'd0);
   endtask

   task automatic test_wrap_and_top_bucket();
      send_event(KIND_WAKE,   14'd1, '1,               5'd0);
      send_event(KIND_SWITCH, 14'd1, '0,               5'd0);
      send_event(KIND_WAKE,   14'd2, '1,               5'd0);
      send_event(KIND_SWITCH, 14'd2, {{63{1'b1}}, 1'b0}, 5'd0);
      send_event(KIND_WAKE,   14'd3, '0,               5'd0);
      send_event(KIND_SWITCH, 14'd3, 64'h3FF_FFFF,     5'd0);
   endtask

   task automatic test_histogram_reads();
      send_event(KIND_READ, 14'd0,    64'd0, 5'd0);
      send_event(KIND_READ, 14'h3FFF, '1,    5'd25);
      send_event(KIND_READ, 14'd0,    64'd0, 5'd26);
      send_event(KIND_READ, 14'd0,    64'd0, 5'd27);
      send_event(KIND_READ, 14'd0,    64'd0, 5'd31);
   endtask

   // kind 3 gets no reply and must not touch the table or the histogram
   task automatic test_ignored_kind();
      send_event(KIND_NONE, 14'd0,    64'd0, 5'd0);
      send_event(KIND_NONE, 14'h3FFF, '1,    5'd31);
      send_event(KIND_READ, 14'd0,    64'd0, 5'd0);
   endtask

   function automatic logic [TIME_W-1:0] random_wait();
      int unsigned bits;
      logic [TIME_W-1:0] v;
      bits = $urandom_range(TIME_W);
      v    = {$urandom, $urandom};
      return (bits == 0) ? '0 : v >> (TIME_W - bits);
   endfunction

   task automatic test_random_traffic(input int n);
      logic [ID_W-1:0] pool[16];
      logic [ID_W-1:0] id;
      logic [TIME_W-1:0] t;
      wlh_kind_type k;
      int unsigned roll;
      int sent;
      foreach (pool[i]) pool[i] = ID_W'($urandom_range(NIDS - 1));
      sent = 0;
      while (sent < n) begin
         id   = ($urandom_range(9) < 8) ? pool[$urandom_range(15)] : ID_W'($urandom);
         t    = {$urandom, $urandom};
         roll = $urandom_range(99);
         if (roll < 40) begin
            k = KIND_WAKE;
         end else if (roll < 80) begin
            k = KIND_SWITCH;
            if (woken[id]) t = woken_at[id] + random_wait();
         end else if (roll < 95) begin
            k = KIND_READ;
         end else begin
            k = KIND_NONE;
         end
         send_event(k, id, t, BUCKET_W'($urandom));
         if (k != KIND_NONE) sent++;
      end
   endtask

   initial begin
      reset              = 1'b1;
      send_idle_pct      = 0;
      stall_pct          = 0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_NONE;
      req_ch.task_id     = '0;
      req_ch.now_ns      = '0;
      req_ch.read_bucket = '0;
      foreach (wait_hist[i]) wait_hist[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_exact_waits();
      test_missing_wakeup();
      test_rewake();
      test_wrap_and_top_bucket();
      test_histogram_reads();
      test_ignored_kind();
      wait_all_replies();

      send_idle_pct = 0;  stall_pct = 0;
      test_random_traffic(275);
      wait_all_replies();
      send_idle_pct = 72; stall_pct = 0;
      test_random_traffic(275);
      wait_all_replies();
      send_idle_pct = 0;  stall_pct = 72;
      test_random_traffic(275);
      wait_all_replies();
      send_idle_pct = 36; stall_pct = 36;
      test_random_traffic(275);
      wait_all_replies();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fails == 0 && replies_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
